// ===== rtl/core/mlq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlq_pkg
// Shared types, codes and defaults of the multi-priority linked queue.
// ----------------------------------------------------------------------------
package mlq_pkg;

  localparam int DEF_NUM_SLOTS  = 64;
  localparam int DEF_NUM_LEVELS = 4;
  localparam int ID_W           = 6;

  // operation codes
  localparam logic [1:0] FN_ENQ   = 2'd0;
  localparam logic [1:0] FN_REM   = 2'd1;
  localparam logic [1:0] FN_QUERY = 2'd2;

  // status codes
  localparam logic [1:0] STS_OK         = 2'd0;
  localparam logic [1:0] STS_QUEUED     = 2'd1;
  localparam logic [1:0] STS_NOT_QUEUED = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LINK,
    ST_FIX
  } state_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            head_valid;
    logic [ID_W-1:0] head_id;
    logic            tail_valid;
    logic [ID_W-1:0] tail_id;
    logic            level_head_valid;
    logic [ID_W-1:0] level_head_id;
  } mlq_result_t;

endpackage

// ===== rtl/core/multi_priority_linked_queue.sv =====
// ----------------------------------------------------------------------------
// multi_priority_linked_queue
// Result word: registered after the read, link and fix passes of the accepted
//   input word; held back while m_tready is low.
// Pacing: a new word is taken only after the previous one leaves the fix
//   pass; the read pass and the two link write passes share the single-port
//   next/prev/slot memories.
// Reset: synchronous, then a clearing pass sweeps the slot table, s_tready low.
// ----------------------------------------------------------------------------
// Doubly linked queue of message slots ordered from the highest priority
// level down, FIFO within a level. Enqueue, remove or query one slot per
// word; every result word reports overall head, overall tail and the first
// slot of the queried level.
// ----------------------------------------------------------------------------
module multi_priority_linked_queue #(
  parameter int NUM_SLOTS  = mlq_pkg::DEF_NUM_SLOTS,
  parameter int NUM_LEVELS = mlq_pkg::DEF_NUM_LEVELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [5:0] msg_id, [7:6] priority_req
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [1:0] status, [2] head_valid, [8:3] head_id,
                                 // [9] tail_valid, [15:10] tail_id,
                                 // [16] level_head_valid, [22:17] level_head_id,
                                 // [23] zero
);

  mlq_pkg::mlq_result_t res;
  logic                 res_load;
  logic                 out_free;

  // the output register may take a new word once it is empty or being drained
  assign out_free = !m_tvalid || m_tready;

  mlq_engine #(
    .NUM_SLOTS (NUM_SLOTS),
    .NUM_LEVELS(NUM_LEVELS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_func (s_tuser),
    .in_id   (s_tdata[5:0]),
    .in_prio (s_tdata[7:6]),
    .out_free(out_free),
    .res_load(res_load),
    .res     (res)
  );

  // hold valid until taken; load a fresh result when the engine finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // pack fields lowest first
  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= {1'b0,
                  res.level_head_id, res.level_head_valid,
                  res.tail_id, res.tail_valid,
                  res.head_id, res.head_valid,
                  res.status};
    end
  end

endmodule

// ===== rtl/core/mlq_ram.sv =====
// ----------------------------------------------------------------------------
// mlq_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mlq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/mlq_engine.sv =====
// ----------------------------------------------------------------------------
// mlq_engine
// Sequencer for list operations: reads slot links, rewrites links in up to two
// passes and keeps head, per-level tails and per-level heads in registers.
// ----------------------------------------------------------------------------
module mlq_engine #(
  parameter int NUM_SLOTS  = mlq_pkg::DEF_NUM_SLOTS,
  parameter int NUM_LEVELS = mlq_pkg::DEF_NUM_LEVELS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_func,
  input  logic [mlq_pkg::ID_W-1:0] in_id,
  input  logic [1:0]               in_prio,
  input  logic                     out_free,
  output logic                     res_load,
  output mlq_pkg::mlq_result_t     res
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int XW = (SW > mlq_pkg::ID_W) ? SW : mlq_pkg::ID_W;

  typedef struct packed {
    logic          vld;
    logic [SW-1:0] idx;
  } link_t;

  typedef struct packed {
    logic          queued;
    logic [LW-1:0] level;
  } info_t;

  mlq_pkg::state_t state, state_next;

  logic [SW-1:0] clr_cnt;
  logic          clr_last;

  link_t head;
  link_t tails  [NUM_LEVELS];
  link_t lheads [NUM_LEVELS];

  logic [1:0]    op_func;
  logic [SW-1:0] op_idx;
  logic          op_id_ok;
  logic [LW-1:0] op_lvl;
  link_t         before_r;
  link_t         after_r;
  logic [LW-1:0] rm_lvl;
  logic [1:0]    status_r;
  logic          do_op;

  // incoming word decode
  logic [XW-1:0] in_id_x;
  logic [SW-1:0] in_idx;
  logic [LW-1:0] in_lvl;
  logic          in_id_ok;
  link_t         ins_before;
  logic          accept;

  // memory ports
  logic          nx_we, pv_we, if_we;
  logic [SW-1:0] nx_addr, pv_addr, if_addr;
  link_t         nx_wdata, pv_wdata, nx_rdata, pv_rdata;
  info_t         if_wdata, if_rdata;

  // read-phase decisions
  logic [1:0] rd_status;
  logic       rd_ok;
  link_t      rd_after;

  // overall tail and result helpers
  link_t                   all_tail;
  logic [XW-1:0]           hx, tx, lx;
  logic [NUM_LEVELS-1:0]   tl_vld, lh_vld;

  assign in_id_x  = XW'(in_id);
  assign in_idx   = in_id_x[SW-1:0];
  assign in_id_ok = (int'(in_id) < NUM_SLOTS);
  assign accept   = in_valid && in_ready;
  assign clr_last = (clr_cnt == SW'(NUM_SLOTS - 1));

  always_comb begin
    if (int'(in_prio) >= NUM_LEVELS) begin
      in_lvl = LW'(NUM_LEVELS - 1);
    end else begin
      in_lvl = LW'(in_prio);
    end
  end

  // insert point: tail of the nearest populated level at or above in_lvl
  always_comb begin
    ins_before = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (l >= int'(in_lvl) && tails[l].vld) begin
        ins_before = tails[l];
      end
    end
  end

  // lowest populated level holds the overall tail
  always_comb begin
    all_tail = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (tails[l].vld) begin
        all_tail = tails[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      tl_vld[l] = tails[l].vld;
      lh_vld[l] = lheads[l].vld;
    end
  end

  mlq_ram #(.DEPTH(NUM_SLOTS), .WIDTH(SW + 1)) u_next (
    .clk(clk), .we(nx_we), .addr(nx_addr), .wdata(nx_wdata), .rdata(nx_rdata)
  );

  mlq_ram #(.DEPTH(NUM_SLOTS), .WIDTH(SW + 1)) u_prev (
    .clk(clk), .we(pv_we), .addr(pv_addr), .wdata(pv_wdata), .rdata(pv_rdata)
  );

  mlq_ram #(.DEPTH(NUM_SLOTS), .WIDTH(LW + 1)) u_info (
    .clk(clk), .we(if_we), .addr(if_addr), .wdata(if_wdata), .rdata(if_rdata)
  );

  // read phase: classify the request
  always_comb begin
    rd_status = mlq_pkg::STS_OK;
    rd_ok     = 1'b0;
    rd_after  = nx_rdata;
    if (op_func == mlq_pkg::FN_ENQ) begin
      rd_after = before_r.vld ? nx_rdata : head;
      if (!op_id_ok) begin
        rd_status = mlq_pkg::STS_NOT_QUEUED;
      end else if (if_rdata.queued) begin
        rd_status = mlq_pkg::STS_QUEUED;
      end else begin
        rd_ok = 1'b1;
      end
    end else if (op_func == mlq_pkg::FN_REM) begin
      if (!op_id_ok || !if_rdata.queued) begin
        rd_status = mlq_pkg::STS_NOT_QUEUED;
      end else begin
        rd_ok = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mlq_pkg::ST_CLEAR: if (clr_last) state_next = mlq_pkg::ST_IDLE;
      mlq_pkg::ST_IDLE:  if (in_valid) state_next = mlq_pkg::ST_READ;
      mlq_pkg::ST_READ:  state_next = mlq_pkg::ST_LINK;
      mlq_pkg::ST_LINK:  state_next = mlq_pkg::ST_FIX;
      mlq_pkg::ST_FIX:   if (out_free) state_next = mlq_pkg::ST_IDLE;
      default:           state_next = mlq_pkg::ST_CLEAR;
    endcase
  end

  // outputs: memory ports and handshake
  always_comb begin
    in_ready = 1'b0;
    res_load = 1'b0;
    nx_we    = 1'b0;
    pv_we    = 1'b0;
    if_we    = 1'b0;
    nx_addr  = op_idx;
    pv_addr  = op_idx;
    if_addr  = op_idx;
    nx_wdata = '0;
    pv_wdata = '0;
    if_wdata = '0;
    unique case (state)
      mlq_pkg::ST_CLEAR: begin
        if_we   = 1'b1;
        if_addr = clr_cnt;
      end
      mlq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        pv_addr  = in_idx;
        if_addr  = in_idx;
        nx_addr  = (in_func == mlq_pkg::FN_ENQ && ins_before.vld) ? ins_before.idx : in_idx;
      end
      mlq_pkg::ST_READ: begin
      end
      mlq_pkg::ST_LINK: begin
        if (do_op && op_func == mlq_pkg::FN_ENQ) begin
          nx_we    = 1'b1;
          nx_wdata = after_r;
          pv_we    = 1'b1;
          pv_wdata = before_r;
          if_we    = 1'b1;
          if_wdata = '{queued: 1'b1, level: op_lvl};
        end else if (do_op) begin
          if_we    = 1'b1;
          pv_we    = after_r.vld;
          pv_addr  = after_r.idx;
          pv_wdata = before_r;
          nx_we    = before_r.vld;
          nx_addr  = before_r.idx;
          nx_wdata = after_r;
        end
      end
      mlq_pkg::ST_FIX: begin
        res_load = out_free;
        if (do_op && op_func == mlq_pkg::FN_ENQ) begin
          nx_we    = before_r.vld;
          nx_addr  = before_r.idx;
          nx_wdata = '{vld: 1'b1, idx: op_idx};
          pv_we    = after_r.vld;
          pv_addr  = after_r.idx;
          pv_wdata = '{vld: 1'b1, idx: op_idx};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mlq_pkg::ST_CLEAR;
      clr_cnt <= '0;
      head    <= '0;
      do_op   <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        tails[l]  <= '0;
        lheads[l] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == mlq_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + SW'(1);
      end
      if (state == mlq_pkg::ST_READ) begin
        do_op <= rd_ok;
      end
      if (state == mlq_pkg::ST_LINK && do_op) begin
        if (op_func == mlq_pkg::FN_ENQ) begin
          if (!before_r.vld) begin
            head <= '{vld: 1'b1, idx: op_idx};
          end
          tails[op_lvl] <= '{vld: 1'b1, idx: op_idx};
          if (!tails[op_lvl].vld) begin
            lheads[op_lvl] <= '{vld: 1'b1, idx: op_idx};
          end
        end else begin
          if (head.vld && head.idx == op_idx) begin
            head <= after_r;
          end
          // repair the level: tail falls back, head moves on
          if (tails[rm_lvl].vld && tails[rm_lvl].idx == op_idx) begin
            tails[rm_lvl] <= (lheads[rm_lvl].vld && lheads[rm_lvl].idx == op_idx)
                             ? link_t'('0) : before_r;
          end
          if (lheads[rm_lvl].vld && lheads[rm_lvl].idx == op_idx) begin
            lheads[rm_lvl] <= (tails[rm_lvl].vld && tails[rm_lvl].idx == op_idx)
                              ? link_t'('0) : after_r;
          end
        end
      end
    end
  end

  // operation payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func  <= in_func;
      op_idx   <= in_idx;
      op_id_ok <= in_id_ok;
      op_lvl   <= in_lvl;
      before_r <= ins_before;
    end
    if (state == mlq_pkg::ST_READ) begin
      status_r <= rd_status;
      after_r  <= rd_after;
      rm_lvl   <= if_rdata.level;
      if (op_func == mlq_pkg::FN_REM) begin
        before_r <= pv_rdata;
      end
    end
  end

  assign hx = XW'(head.idx);
  assign tx = XW'(all_tail.idx);
  assign lx = XW'(lheads[op_lvl].idx);

  always_comb begin
    res.status           = status_r;
    res.head_valid       = head.vld;
    res.head_id          = head.vld ? hx[mlq_pkg::ID_W-1:0] : '0;
    res.tail_valid       = all_tail.vld;
    res.tail_id          = all_tail.vld ? tx[mlq_pkg::ID_W-1:0] : '0;
    res.level_head_valid = lheads[op_lvl].vld;
    res.level_head_id    = lheads[op_lvl].vld ? lx[mlq_pkg::ID_W-1:0] : '0;
  end

  a_level_pair: assert property (@(posedge clk) disable iff (rst)
    tl_vld == lh_vld)
    else $error("level head and tail disagree on occupancy");

  a_head_any: assert property (@(posedge clk) disable iff (rst)
    head.vld == (|tl_vld))
    else $error("queue head valid does not match level occupancy");

  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    ((state == mlq_pkg::ST_LINK || state == mlq_pkg::ST_FIX) && !do_op)
      |-> !(nx_we || pv_we || if_we))
    else $error("memory written for a rejected or query word");

  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    (state == mlq_pkg::ST_IDLE && $past(state) == mlq_pkg::ST_CLEAR)
      |-> $past(clr_cnt) == SW'(NUM_SLOTS - 1))
    else $error("clearing pass ended early");

endmodule

// ===== test/mlq_result_checker.sv =====
// ----------------------------------------------------------------------------
// mlq_result_checker
// Watches both streams of the linked queue, predicts each result word and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module mlq_result_checker #(
  parameter int NUM_SLOTS  = mlq_pkg::DEF_NUM_SLOTS,
  parameter int NUM_LEVELS = mlq_pkg::DEF_NUM_LEVELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [5:0] msg_id, [7:6] priority_req
  input  logic [1:0]  s_tuser,   // [1:0] func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // [1:0] status, [2] head_valid, [8:3] head_id,
                                 // [9] tail_valid, [15:10] tail_id,
                                 // [16] level_head_valid, [22:17] level_head_id
  output int          outstanding,
  output int          failures
);
  timeunit 1ns;
  timeprecision 1ps;

  import mlq_pkg::*;

  localparam int LINK_W     = $clog2(NUM_SLOTS) + 1;
  localparam int PRINT_CAP  = 50;

  typedef logic [LINK_W-1:0] link_t;
  localparam link_t NIL = link_t'(NUM_SLOTS);

  // shadow copy of the slot table
  link_t       slot_next [NUM_SLOTS];
  link_t       slot_prev [NUM_SLOTS];
  logic [1:0]  slot_lvl  [NUM_SLOTS];
  logic        slot_busy [NUM_SLOTS];
  link_t       lvl_tail  [NUM_LEVELS];
  link_t       q_head;

  mlq_result_t pending_views[$];

  task automatic report_mismatch(string what);
    if (failures < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    failures++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic link_t tail_from(int lvl);
    for (int l = lvl; l < NUM_LEVELS; l++)
      if (lvl_tail[l] != NIL) return lvl_tail[l];
    return NIL;
  endfunction

  function automatic link_t level_first(int lvl);
    link_t above;
    if (lvl_tail[lvl] == NIL) return NIL;
    if (q_head != NIL && slot_lvl[q_head] == lvl) return q_head;
    above = tail_from(lvl + 1);
    if (above == NIL) return NIL;
    return slot_next[above];
  endfunction

  function automatic logic [1:0] insert_slot(link_t id, int lvl);
    link_t pre, post;
    if (slot_busy[id]) return STS_QUEUED;
    pre = tail_from(lvl);
    if (pre == NIL) begin
      post   = q_head;
      q_head = id;
    end else begin
      post           = slot_next[pre];
      slot_next[pre] = id;
    end
    slot_prev[id] = pre;
    slot_next[id] = post;
    if (post != NIL) slot_prev[post] = id;
    lvl_tail[lvl] = id;
    slot_lvl[id]  = lvl[1:0];
    slot_busy[id] = 1'b1;
    return STS_OK;
  endfunction

  function automatic logic [1:0] unlink_slot(link_t id);
    int    lvl;
    link_t pre, post;
    if (!slot_busy[id]) return STS_NOT_QUEUED;
    lvl  = slot_lvl[id];
    pre  = slot_prev[id];
    post = slot_next[id];
    // the level tail falls back to the predecessor only if it shares the level
    if (lvl_tail[lvl] == id) begin
      lvl_tail[lvl] = NIL;
      if (pre != NIL) begin
        if (slot_lvl[pre] == lvl) lvl_tail[lvl] = pre;
      end
    end
    if (q_head == id) q_head = post;
    if (post != NIL) slot_prev[post] = pre;
    if (pre != NIL) slot_next[pre] = post;
    slot_next[id] = NIL;
    slot_prev[id] = NIL;
    slot_busy[id] = 1'b0;
    return STS_OK;
  endfunction

  function automatic mlq_result_t apply_word(logic [1:0] fn, logic [5:0] id, logic [1:0] lvl);
    mlq_result_t r;
    link_t       h, t, lh;
    r.status = STS_OK;
    if (fn == FN_ENQ) r.status = insert_slot(link_t'(id), lvl);
    else if (fn == FN_REM) r.status = unlink_slot(link_t'(id));
    h  = q_head;
    t  = tail_from(0);
    lh = level_first(lvl);
    r.head_valid       = (h != NIL);
    r.head_id          = (h != NIL) ? h[ID_W-1:0] : '0;
    r.tail_valid       = (t != NIL);
    r.tail_id          = (t != NIL) ? t[ID_W-1:0] : '0;
    r.level_head_valid = (lh != NIL);
    r.level_head_id    = (lh != NIL) ? lh[ID_W-1:0] : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    mlq_result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_next[i] = '0;
        slot_prev[i] = '0;
        slot_lvl[i]  = '0;
        slot_busy[i] = 1'b0;
      end
      for (int l = 0; l < NUM_LEVELS; l++) lvl_tail[l] = NIL;
      q_head = NIL;
      pending_views.delete();
      failures = 0;
      outstanding <= 0;
    end else begin
      // retire before predicting, so a result never meets its own input
      if (m_tvalid && m_tready) begin
        if (pending_views.size() == 0) begin
          report_mismatch($sformatf("result word 0x%06h with nothing expected", m_tdata));
        end else begin
          want = pending_views.pop_front();
          check_field("status",           m_tdata[1:0],   want.status);
          check_field("head_valid",       m_tdata[2],     want.head_valid);
          check_field("head_id",          m_tdata[8:3],   want.head_id);
          check_field("tail_valid",       m_tdata[9],     want.tail_valid);
          check_field("tail_id",          m_tdata[15:10], want.tail_id);
          check_field("level_head_valid", m_tdata[16],    want.level_head_valid);
          check_field("level_head_id",    m_tdata[22:17], want.level_head_id);
        end
      end
      if (s_tvalid && s_tready)
        pending_views.push_back(apply_word(s_tuser, s_tdata[5:0], s_tdata[7:6]));
      outstanding <= pending_views.size();
    end
  end

endmodule

// ===== test/multi_priority_linked_queue_test.sv =====
// ----------------------------------------------------------------------------
// multi_priority_linked_queue_test
// Drives enqueue, remove and query words into the linked priority queue and
// lets the result checker compare every returned word with its prediction.
// ----------------------------------------------------------------------------
module multi_priority_linked_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mlq_pkg::*;

  localparam int NUM_SLOTS    = DEF_NUM_SLOTS;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_WORDS = 800;
  localparam int IDLE_PCT     = 8;
  localparam int DRAIN_CYCLES = 20;
  // the clearing pass after reset is the longest quiet spell of a sound run
  localparam int STALL_LIMIT  = 2000;

  // spare function code: the block treats it as a query without an operation
  localparam logic [1:0] FN_SPARE = 2'd3;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [5:0] msg_id, [7:6] priority_req
  logic [1:0]  s_tuser  = '0;   // [1:0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [1:0] status, [2] head_valid, [8:3] head_id,
                                // [9] tail_valid, [15:10] tail_id,
                                // [16] level_head_valid, [22:17] level_head_id

  int outstanding;
  int failures;
  int stall_cycles = 0;

  // calm switches off idling on both sides for a stretch of the run
  bit calm = 1'b0;

  // which slots the stimulus believes are queued; used only to bias choices
  bit live [NUM_SLOTS];
  int live_count = 0;

  always #5 clk = ~clk;

  multi_priority_linked_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  mlq_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .outstanding (outstanding),
    .failures    (failures)
  );

  // Stall the result side now and then, never during the calm stretch.
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Count cycles with no word moving on either side; give up at the limit.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one word, maybe after a short idle gap, and hold it until taken.
  task automatic send_word(logic [1:0] fn, logic [5:0] id, logic [1:0] lvl);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {lvl, id};
    do @(posedge clk); while (!s_tready);
    // a free slot always enqueues and a queued one always unlinks
    if (fn == FN_ENQ && !live[id]) begin
      live[id] = 1'b1;
      live_count++;
    end else if (fn == FN_REM && live[id]) begin
      live[id] = 1'b0;
      live_count--;
    end
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Find a slot whose queued state matches want, scanning from a random start.
  function automatic bit pick_id(bit want, output logic [5:0] id);
    int start;
    start = $urandom_range(NUM_SLOTS - 1);
    id    = start[5:0];
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (live[(start + k) % NUM_SLOTS] == want) begin
        id = 6'((start + k) % NUM_SLOTS);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  initial begin
    int         roll;
    int         target;
    logic [1:0] fn;
    logic [5:0] id;
    bit         found;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed words: empty queue, error codes, every level, head and tail
    // removal, tail repair within and across levels, and the spare code.
    send_word(FN_QUERY, 6'd0,  2'd0);   // empty: all ids must read as zero
    send_word(FN_REM,   6'd5,  2'd0);   // remove of a free slot
    send_word(FN_SPARE, 6'd63, 2'd3);   // spare code on an empty queue
    send_word(FN_ENQ,   6'd0,  2'd0);   // lowest id, lowest level
    send_word(FN_ENQ,   6'd63, 2'd3);   // highest id, goes to the head
    send_word(FN_ENQ,   6'd0,  2'd2);   // already queued
    send_word(FN_ENQ,   6'd21, 2'd1);   // between two populated levels
    send_word(FN_ENQ,   6'd42, 2'd1);   // fifo order within a level
    send_word(FN_ENQ,   6'd10, 2'd2);   // empty level right below the head
    send_word(FN_QUERY, 6'd0,  2'd1);
    send_word(FN_QUERY, 6'd0,  2'd2);
    send_word(FN_REM,   6'd42, 2'd0);   // level tail falls back within level
    send_word(FN_REM,   6'd21, 2'd0);   // level tail with predecessor above
    send_word(FN_QUERY, 6'd0,  2'd1);   // now empty level
    send_word(FN_REM,   6'd63, 2'd0);   // overall head
    send_word(FN_ENQ,   6'd63, 2'd3);   // reuse of a freed slot
    send_word(FN_SPARE, 6'd0,  2'd1);   // spare code on a busy queue
    send_word(FN_REM,   6'd0,  2'd0);   // overall tail
    send_word(FN_REM,   6'd0,  2'd0);   // second remove of the same slot
    send_word(FN_ENQ,   6'd33, 2'd0);
    send_word(FN_ENQ,   6'd34, 2'd0);
    send_word(FN_REM,   6'd63, 2'd0);
    send_word(FN_REM,   6'd10, 2'd0);
    send_word(FN_REM,   6'd33, 2'd0);
    send_word(FN_REM,   6'd34, 2'd3);   // queue runs empty again

    wait_drained();

    // Random words: mostly legal enqueues and removes steered toward a
    // moving fill target, plus queries, spare codes and error noise.
    target = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) target = $urandom_range(NUM_SLOTS);
      calm <= (n >= 200 && n < 350);
      if (n == 450) wait_drained();
      roll = $urandom_range(99);
      id   = 6'($urandom_range(NUM_SLOTS - 1));
      if (roll < 4) begin
        fn = FN_SPARE;
      end else if (roll < 18) begin
        fn = FN_QUERY;
      end else if (roll < 24) begin
        // noise: any slot, legal or not
        fn = $urandom_range(1) ? FN_REM : FN_ENQ;
      end else if ((live_count < target) ? ($urandom_range(99) < 80)
                                         : ($urandom_range(99) < 20)) begin
        fn    = FN_ENQ;
        found = pick_id(1'b0, id);
        if (!found) fn = FN_QUERY;
      end else begin
        fn    = FN_REM;
        found = pick_id(1'b1, id);
        if (!found) fn = FN_QUERY;
      end
      send_word(fn, id, 2'($urandom_range(3)));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
